// File: rtl/swrf_pkg.sv
package swrf_pkg;

    typedef enum logic [1:0] {
        MODE_MAX    = 2'd0,
        MODE_MIN    = 2'd1,
        MODE_MEAN   = 2'd2,
        MODE_MEDIAN = 2'd3
    } mode_t;

    localparam logic CFG_WINDOW_SIZE = 1'b0;
    localparam logic CFG_MODE        = 1'b1;

    localparam int WIN_BITS = 4;
    localparam int DEN_BITS = WIN_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_ADVANCE
    } state_t;

    typedef struct packed {
        logic push;
        logic push_zero;
        logic clear;
        logic scan_step;
        logic div_start;
        logic load_out;
        logic run_end;
        logic array_end;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_last;
        logic div_busy;
        logic out_free;
    } status_t;

    // clamp to MAX_WINDOW (maxw), then force odd (zero becomes one)
    function automatic logic [WIN_BITS-1:0] eff_window(input logic [WIN_BITS-1:0] ws,
                                                      input int unsigned maxw);
        logic [WIN_BITS-1:0] w;
        w = (32'(ws) > maxw) ? WIN_BITS'(maxw) : ws;
        if (!w[0])
        begin
            w = (w == '0) ? WIN_BITS'(1) : w - WIN_BITS'(1);
        end
        return w;
    endfunction

endpackage

// File: rtl/sliding_window_rank_filter.sv
// Flow: max, min and median give a result after a rank scan (one window entry
// a cycle); mean sums the window in the scan, then divides in a divider of width
// NB = SAMPLE_BITS+clog2(MAX_WINDOW)+1, one quotient bit a cycle. Throughput: one
// item at a time; an item ending an array adds up to one such pass for each of
// its (W-1)/2 flush positions. The output register lets the next item in.
// Reset (rst_n, asynchronous): history cleared to zero, window 3, mode maximum.
module sliding_window_rank_filter #(
    parameter int MAX_WINDOW  = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic                          cfg_index,
    input  logic [3:0]                    cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last_sample,
    output logic                          filtered_valid,
    input  logic                          filtered_stall,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          run_end,
    output logic                          array_end
);

    localparam int WB = swrf_pkg::WIN_BITS;

    logic [WB-1:0]     window_size_reg, window_size_next;
    swrf_pkg::mode_t   mode_reg, mode_next;
    logic [WB-1:0]     window;
    swrf_pkg::cmd_t    cmd;
    swrf_pkg::status_t status;

    always_comb
    begin
        window_size_next = window_size_reg;
        mode_next        = mode_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                swrf_pkg::CFG_WINDOW_SIZE: window_size_next = cfg_data;
                swrf_pkg::CFG_MODE:        mode_next = swrf_pkg::mode_t'(cfg_data[1:0]);
                default:                   window_size_next = window_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WB'(3);
            mode_reg        <= swrf_pkg::MODE_MAX;
        end
        else
        begin
            window_size_reg <= window_size_next;
            mode_reg        <= mode_next;
        end
    end

    assign window = swrf_pkg::eff_window(window_size_reg, MAX_WINDOW);

    swrf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .window      (window),
        .mode        (mode_reg),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .last_sample (last_sample),
        .status      (status),
        .cmd         (cmd)
    );

    swrf_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .window        (window),
        .mode          (mode_reg),
        .sample        (sample),
        .status        (status),
        .filtered_valid(filtered_valid),
        .filtered_stall(filtered_stall),
        .filtered      (filtered),
        .run_end       (run_end),
        .array_end     (array_end)
    );

endmodule

// File: rtl/swrf_divider.sv
module swrf_divider #(
    parameter int NUM_BITS = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_BITS-1:0]           numerator,
    input  logic [swrf_pkg::DEN_BITS-1:0] denominator,
    output logic                          busy,
    output logic [NUM_BITS-1:0]           quotient
);

    localparam int DW = swrf_pkg::DEN_BITS;
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [DW-1:0]       den_reg, den_next;
    logic [DW:0]         rem_shift;
    logic [DW:0]         diff;
    logic                ge;

    // one quotient bit a cycle, restoring
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUM_BITS-1]};
        diff      = rem_shift - {1'b0, den_reg};
        ge        = !diff[DW];
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next = CW'(NUM_BITS);
            num_next = numerator;
            rem_next = '0;
            den_next = denominator;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CW'(1);
            num_next = {num_reg[NUM_BITS-2:0], ge};
            rem_next = ge ? diff[DW-1:0] : rem_shift[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = num_reg;

endmodule

// File: rtl/swrf_datapath.sv
module swrf_datapath #(
    parameter int MAX_WINDOW  = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swrf_pkg::cmd_t                cmd,
    input  logic [swrf_pkg::WIN_BITS-1:0] window,
    input  swrf_pkg::mode_t               mode,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output swrf_pkg::status_t             status,
    output logic                          filtered_valid,
    input  logic                          filtered_stall,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          run_end,
    output logic                          array_end
);

    localparam int WB   = swrf_pkg::WIN_BITS;
    localparam int IW   = $clog2(MAX_WINDOW);
    localparam int SUMW = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int NW   = SUMW + 1;

    logic signed [SAMPLE_BITS-1:0] sh_reg [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] sh_next [MAX_WINDOW];
    logic [IW-1:0]                 idx_reg, idx_next;
    logic signed [SUMW-1:0]        sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] result_reg, result_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] filtered_reg, filtered_next;
    logic                          run_end_reg, run_end_next;
    logic                          array_end_reg, array_end_next;

    logic signed [SAMPLE_BITS-1:0] cand;
    logic [MAX_WINDOW-1:0]         lt_vec, le_vec;
    logic [WB-1:0]                 cnt_lt, cnt_le, rank_k;
    logic                          hit;
    logic                          sum_neg;
    logic [SUMW-1:0]               sum_abs;
    logic [NW-1:0]                 numerator;
    logic [NW-1:0]                 quotient;
    logic                          div_busy;
    logic [SAMPLE_BITS-1:0]        q_low;
    logic signed [SAMPLE_BITS-1:0] mean_val;
    logic signed [SAMPLE_BITS-1:0] out_val;
    logic                          out_free;

    // rank of the candidate against the whole window
    always_comb
    begin
        cand = sh_reg[idx_reg];
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            lt_vec[j] = (j < 32'(window)) && (sh_reg[j] <  cand);
            le_vec[j] = (j < 32'(window)) && (sh_reg[j] <= cand);
        end
        cnt_lt = WB'($countones(lt_vec));
        cnt_le = WB'($countones(le_vec));
        case (mode)
            swrf_pkg::MODE_MAX:    rank_k = window - WB'(1);
            swrf_pkg::MODE_MIN:    rank_k = '0;
            swrf_pkg::MODE_MEAN:   rank_k = window >> 1;
            swrf_pkg::MODE_MEDIAN: rank_k = window >> 1;
            default:               rank_k = window >> 1;
        endcase
        hit = (cnt_lt <= rank_k) && (rank_k < cnt_le);
    end

    always_comb
    begin
        sum_neg   = sum_reg[SUMW-1];
        sum_abs   = sum_neg ? (~sum_reg + SUMW'(1)) : sum_reg;
        numerator = {sum_abs, 1'b0} + NW'(window);
        q_low     = quotient[SAMPLE_BITS-1:0];
        mean_val  = sum_neg ? -q_low : q_low;
        out_val   = (mode == swrf_pkg::MODE_MEAN) ? mean_val : result_reg;
        out_free  = !out_valid_reg || !filtered_stall;
    end

    swrf_divider #(
        .NUM_BITS(NW)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.div_start),
        .numerator  (numerator),
        .denominator({window, 1'b0}),
        .busy       (div_busy),
        .quotient   (quotient)
    );

    always_comb
    begin
        sh_next        = sh_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && filtered_stall;
        filtered_next  = filtered_reg;
        run_end_next   = run_end_reg;
        array_end_next = array_end_reg;
        if (cmd.clear)
        begin
            for (int j = 0; j < MAX_WINDOW; j++)
            begin
                sh_next[j] = '0;
            end
        end
        else if (cmd.push)
        begin
            sh_next[0] = cmd.push_zero ? '0 : sample;
            for (int j = 1; j < MAX_WINDOW; j++)
            begin
                sh_next[j] = sh_reg[j-1];
            end
        end
        if (cmd.push)
        begin
            idx_next = '0;
            sum_next = '0;
        end
        else if (cmd.scan_step)
        begin
            idx_next = idx_reg + IW'(1);
            sum_next = sum_reg + SUMW'(cand);
            if (hit)
            begin
                result_next = cand;
            end
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            filtered_next  = out_val;
            run_end_next   = cmd.run_end;
            array_end_next = cmd.array_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_WINDOW; j++)
            begin
                sh_reg[j] <= '0;
            end
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sh_reg        <= sh_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        result_reg    <= result_next;
        filtered_reg  <= filtered_next;
        run_end_reg   <= run_end_next;
        array_end_reg <= array_end_next;
    end

    assign status.hit       = hit;
    assign status.scan_last = (32'(idx_reg) + 32'd1 == 32'(window));
    assign status.div_busy  = div_busy;
    assign status.out_free  = out_free;

    assign filtered_valid = out_valid_reg;
    assign filtered       = filtered_reg;
    assign run_end        = run_end_reg;
    assign array_end      = array_end_reg;

endmodule

// File: rtl/swrf_ctrl.sv
module swrf_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [swrf_pkg::WIN_BITS-1:0] window,
    input  swrf_pkg::mode_t               mode,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic                          last_sample,
    input  swrf_pkg::status_t             status,
    output swrf_pkg::cmd_t                cmd
);

    localparam int WB = swrf_pkg::WIN_BITS;
    localparam int PB = WB - 1;

    swrf_pkg::state_t state_reg, state_next;
    logic [WB-1:0]    seen_reg, seen_next;
    logic [PB-1:0]    flush_reg, flush_next;
    logic             last_reg, last_next;

    logic [PB-1:0]    pad;
    logic             emit_now;
    logic [WB-1:0]    seen_sat;
    logic             flush_more;
    logic             final_push;

    always_comb
    begin
        pad        = PB'((window - WB'(1)) >> 1);
        emit_now   = (seen_reg >= {1'b0, pad});
        seen_sat   = (seen_reg == '1) ? seen_reg : seen_reg + WB'(1);
        flush_more = last_reg && (flush_reg != '0);
        final_push = !last_reg || (flush_reg == '0);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swrf_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = emit_now ? swrf_pkg::ST_SCAN : swrf_pkg::ST_ADVANCE;
                end
            end
            swrf_pkg::ST_SCAN:
            begin
                if (mode == swrf_pkg::MODE_MEAN)
                begin
                    if (status.scan_last)
                    begin
                        state_next = swrf_pkg::ST_DIV_START;
                    end
                end
                else if (status.hit || status.scan_last)
                begin
                    state_next = swrf_pkg::ST_EMIT;
                end
            end
            swrf_pkg::ST_DIV_START:
            begin
                state_next = swrf_pkg::ST_DIV_WAIT;
            end
            swrf_pkg::ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = swrf_pkg::ST_EMIT;
                end
            end
            swrf_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = swrf_pkg::ST_ADVANCE;
                end
            end
            swrf_pkg::ST_ADVANCE:
            begin
                if (flush_more)
                begin
                    state_next = emit_now ? swrf_pkg::ST_SCAN : swrf_pkg::ST_ADVANCE;
                end
                else
                begin
                    state_next = swrf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        sample_stall = 1'b1;
        unique case (state_reg)
            swrf_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                cmd.push     = sample_valid;
            end
            swrf_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            swrf_pkg::ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
            end
            swrf_pkg::ST_DIV_WAIT:
            begin
                cmd = '0;
            end
            swrf_pkg::ST_EMIT:
            begin
                cmd.load_out  = status.out_free;
                cmd.run_end   = final_push;
                cmd.array_end = final_push && last_reg;
            end
            swrf_pkg::ST_ADVANCE:
            begin
                cmd.push      = flush_more;
                cmd.push_zero = flush_more;
                cmd.clear     = !flush_more && last_reg;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        seen_next  = seen_reg;
        flush_next = flush_reg;
        last_next  = last_reg;
        if (state_reg == swrf_pkg::ST_IDLE && sample_valid)
        begin
            seen_next  = seen_sat;
            flush_next = pad;
            last_next  = last_sample;
        end
        else if (state_reg == swrf_pkg::ST_ADVANCE)
        begin
            if (flush_more)
            begin
                seen_next  = seen_sat;
                flush_next = flush_reg - PB'(1);
            end
            else if (last_reg)
            begin
                seen_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swrf_pkg::ST_IDLE;
            seen_reg  <= '0;
            flush_reg <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            flush_reg <= flush_next;
            last_reg  <= last_next;
        end
    end

endmodule

// File: rtl/swrf_checker.sv
module swrf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sample_valid,
    input logic                          sample_stall,
    input logic                          filtered_valid,
    input logic                          filtered_stall,
    input logic signed [SAMPLE_BITS-1:0] filtered,
    input logic                          run_end,
    input logic                          array_end
);

    // held result item keeps its fields
    assert property (@(posedge clk) disable iff (!rst_n)
        filtered_valid && filtered_stall |=>
            filtered_valid && $stable(filtered) && $stable(run_end) && $stable(array_end))
    else $error("stalled result item changed");

    // the result for the last position always closes its item
    assert property (@(posedge clk) disable iff (!rst_n)
        filtered_valid && array_end |-> run_end)
    else $error("array_end without run_end");

    // a taken item keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
    else $error("second item taken straight after the first");

endmodule

bind sliding_window_rank_filter swrf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);

// File: verif/filter_result_checker.sv
`timescale 1ns / 1ps

module filter_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data,
    input  logic               sample_valid,
    input  logic               sample_stall,
    input  logic signed [15:0] sample,
    input  logic               last_sample,
    input  logic               filtered_valid,
    input  logic               filtered_stall,
    input  logic signed [15:0] filtered,
    input  logic               run_end,
    input  logic               array_end,
    output int                 errors,
    output int                 pending
);

    localparam int HIST_DEPTH = 14;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [15:0] value;
        logic               run_end;
        logic               array_end;
    } filter_result_t;

    filter_result_t     pending_results[$];
    logic signed [15:0] history [HIST_DEPTH];
    logic signed [15:0] win_buf [15];
    int                 samples_in_array;
    logic [3:0]         window_reg;
    swrf_pkg::mode_t    mode_reg;

    // even widths drop to the next odd one, zero becomes one
    function automatic int odd_width(input logic [3:0] ws);
        if (ws == 4'd0)
            return 1;
        if (!ws[0])
            return int'(ws) - 1;
        return int'(ws);
    endfunction

    function automatic logic signed [15:0] window_value(input int w);
        logic signed [15:0] best;
        logic signed [15:0] v;
        logic signed [15:0] sorted [15];
        int                 total;
        int                 mag;
        int                 q;
        int                 i;
        int                 k;
        best = win_buf[0];
        case (mode_reg)
            swrf_pkg::MODE_MAX:
            begin
                for (i = 1; i < w; i++)
                    if (win_buf[i] > best)
                        best = win_buf[i];
            end
            swrf_pkg::MODE_MIN:
            begin
                for (i = 1; i < w; i++)
                    if (win_buf[i] < best)
                        best = win_buf[i];
            end
            swrf_pkg::MODE_MEAN:
            begin
                total = 0;
                for (i = 0; i < w; i++)
                    total += win_buf[i];
                mag = (total < 0) ? -total : total;
                // half away from zero
                q = (2 * mag + w) / (2 * w);
                best = 16'((total < 0) ? -q : q);
            end
            default:
            begin
                for (i = 0; i < w; i++)
                begin
                    v = win_buf[i];
                    k = i;
                    while (k > 0 && sorted[k - 1] > v)
                    begin
                        sorted[k] = sorted[k - 1];
                        k--;
                    end
                    sorted[k] = v;
                end
                best = sorted[w / 2];
            end
        endcase
        return best;
    endfunction

    function automatic logic signed [15:0] shift_in(input logic signed [15:0] v, input int w);
        int j;
        win_buf[0] = v;
        for (j = 1; j < w; j++)
            win_buf[j] = history[j - 1];
        for (j = HIST_DEPTH - 1; j > 0; j--)
            history[j] = history[j - 1];
        history[0] = v;
        return window_value(w);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        filter_result_t got;
        filter_result_t want;
        filter_result_t held;
        logic           have;
        logic signed [15:0] r;
        int             w;
        int             pad;
        int             seen;
        int             k;
        if (!rst_n)
        begin
            for (k = 0; k < HIST_DEPTH; k++)
                history[k] = '0;
            samples_in_array = 0;
            window_reg = 4'd3;
            mode_reg = swrf_pkg::MODE_MAX;
            pending_results.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (filtered_valid && !filtered_stall)
            begin
                got = {filtered, run_end, array_end};
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("unexpected result %0d run_end %b array_end %b",
                                 $signed(got.value), got.run_end, got.array_end);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.value !== want.value || got.run_end !== want.run_end ||
                        got.array_end !== want.array_end)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("result: expected %0d/%b/%b, got %0d/%b/%b",
                                     $signed(want.value), want.run_end, want.array_end,
                                     $signed(got.value), got.run_end, got.array_end);
                    end
                end
            end

            if (sample_valid && !sample_stall)
            begin
                w = odd_width(window_reg);
                pad = (w - 1) / 2;
                seen = samples_in_array;
                have = 1'b0;
                r = shift_in(sample, w);
                if (seen >= pad)
                begin
                    held = {r, 1'b0, 1'b0};
                    have = 1'b1;
                end
                seen++;
                if (last_sample)
                begin
                    // flush the tail with zero padding
                    for (k = 0; k < pad; k++)
                    begin
                        r = shift_in(16'sd0, w);
                        if (seen >= pad)
                        begin
                            if (have)
                                pending_results.push_back(held);
                            held = {r, 1'b0, 1'b0};
                            have = 1'b1;
                        end
                        seen++;
                    end
                    for (k = 0; k < HIST_DEPTH; k++)
                        history[k] = '0;
                    samples_in_array = 0;
                    if (have)
                        held.array_end = 1'b1;
                end
                else
                    samples_in_array = (seen > 15) ? 15 : seen;
                if (have)
                begin
                    held.run_end = 1'b1;
                    pending_results.push_back(held);
                end
            end

            if (cfg_write_en)
            begin
                if (cfg_index == swrf_pkg::CFG_WINDOW_SIZE)
                    window_reg = cfg_data;
                else
                    mode_reg = swrf_pkg::mode_t'(cfg_data[1:0]);
            end

            pending = pending_results.size();
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 100;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 19;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_write_en   = 1'b0;
    logic               cfg_index      = 1'b0;
    logic [3:0]         cfg_data       = 4'd0;
    logic               sample_valid   = 1'b0;
    logic               sample_stall;
    logic signed [15:0] sample         = 16'sd0;
    logic               last_sample    = 1'b0;
    logic               filtered_valid;
    logic               filtered_stall = 1'b0;
    logic signed [15:0] filtered;
    logic               run_end;
    logic               array_end;

    int errors;
    int pending;
    int idle_cycles = 0;
    bit no_idle     = 1'b0;
    bit hold_req    = 1'b0;

    sliding_window_rank_filter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .last_sample    (last_sample),
        .filtered_valid (filtered_valid),
        .filtered_stall (filtered_stall),
        .filtered       (filtered),
        .run_end        (run_end),
        .array_end      (array_end)
    );

    filter_result_checker u_results (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .last_sample    (last_sample),
        .filtered_valid (filtered_valid),
        .filtered_stall (filtered_stall),
        .filtered       (filtered),
        .run_end        (run_end),
        .array_end      (array_end),
        .errors         (errors),
        .pending        (pending)
    );

    always #1 clk = ~clk;

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (filtered_valid && !filtered_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sliding_window_rank_filter: mismatch");
            $finish;
        end
    end

    initial
    begin : receiver
        int gap;
        wait (rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (hold_req)
            begin
                // long hold-off so the block backs up into its input
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                filtered_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            filtered_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!filtered_valid);
        end
    end

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3, 4: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic offer_sample(input logic signed [15:0] value, input logic is_last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        sample       <= value;
        last_sample  <= is_last;
        do
        begin
            @(posedge clk);
        end
        while (sample_stall);
    endtask

    task automatic settle();
        @(negedge clk);
        sample_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [3:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic program_filter(input logic [3:0] ws, input swrf_pkg::mode_t m);
        cfg_write(swrf_pkg::CFG_WINDOW_SIZE, ws);
        // upper data bits are don't-care for the mode register
        cfg_write(swrf_pkg::CFG_MODE, {2'($urandom_range(0, 3)), m});
    endtask

    initial
    begin : stimulus
        int p;
        int i;
        int arr_left;
        arr_left = 0;
        wait (rst_n);

        // reset settings: window 3, maximum
        offer_sample(16'sh7fff, 1'b0);
        offer_sample(16'sh8000, 1'b0);
        offer_sample(16'sd0, 1'b1);
        settle();

        // zero window acts as one; single-item arrays
        program_filter(4'd0, swrf_pkg::MODE_MIN);
        offer_sample(16'sh8000, 1'b1);
        offer_sample(16'sh7fff, 1'b1);
        settle();

        // widest window: array shorter than the pad, then full-scale negative mean
        program_filter(4'd15, swrf_pkg::MODE_MEAN);
        offer_sample(16'sh7fff, 1'b0);
        offer_sample(16'sh7fff, 1'b0);
        offer_sample(16'sh7fff, 1'b1);
        for (i = 0; i < 7; i++)
            offer_sample(16'sh8000, 1'b0);
        offer_sample(16'sh8000, 1'b1);
        settle();

        // even window forced odd; rounding both signs
        program_filter(4'd4, swrf_pkg::MODE_MEAN);
        offer_sample(16'sd1, 1'b0);
        offer_sample(16'sd1, 1'b0);
        offer_sample(-16'sd1, 1'b0);
        offer_sample(-16'sd1, 1'b1);
        settle();

        program_filter(4'd5, swrf_pkg::MODE_MEDIAN);
        offer_sample(16'sd5, 1'b0);
        offer_sample(-16'sd3, 1'b0);
        offer_sample(16'sd5, 1'b0);
        offer_sample(16'sd7, 1'b0);
        offer_sample(-16'sd3, 1'b1);
        settle();

        // random arrays, which may run across a settings change
        for (p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                program_filter(4'd15, swrf_pkg::mode_t'(p % 4));
            else if (p == 1)
                program_filter(4'd1, swrf_pkg::mode_t'(p % 4));
            else
                program_filter(4'($urandom_range(0, 15)), swrf_pkg::mode_t'(p % 4));
            no_idle = (p == 2 || p == 5);
            if (p == 5)
                hold_req = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (arr_left == 0)
                    arr_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                            : $urandom_range(4, 24);
                arr_left--;
                offer_sample(pick_sample(), arr_left == 0);
            end
            settle();
        end
        no_idle = 1'b0;

        if (errors == 0 && pending == 0)
            $display("sliding_window_rank_filter: match");
        else
            $display("sliding_window_rank_filter: mismatch");
        $finish;
    end

endmodule
